/* rtl/numeric_literal_recognizer_defines.svh */
// Assertion macros for the numeric literal recognizer checker.
`ifndef NUMERIC_LITERAL_RECOGNIZER_DEFINES_SVH
`define NUMERIC_LITERAL_RECOGNIZER_DEFINES_SVH

// Checked only outside reset.
`define NLR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define NLR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/nlr_pkg.sv */
// Package: types, state codes and character classes of the literal scanner.
`timescale 1ns / 1ps
package nlr_pkg;

  typedef logic [3:0] scan_state_t;

  localparam scan_state_t ST_START     = 4'd0;
  localparam scan_state_t ST_SIGNED    = 4'd1;
  localparam scan_state_t ST_ZERO      = 4'd2;
  localparam scan_state_t ST_DEC_INT   = 4'd3;
  localparam scan_state_t ST_DEC_DOT   = 4'd4;
  localparam scan_state_t ST_EXP_START = 4'd5;
  localparam scan_state_t ST_EXP_SIGN  = 4'd6;
  localparam scan_state_t ST_EXP_DIG   = 4'd7;
  localparam scan_state_t ST_HEX_START = 4'd8;
  localparam scan_state_t ST_HEX_DIG   = 4'd9;
  localparam scan_state_t ST_BIN_START = 4'd10;
  localparam scan_state_t ST_BIN_DIG   = 4'd11;
  localparam scan_state_t ST_DEAD      = 4'd12;

  localparam logic [1:0] KIND_DEC_INT  = 2'd0;
  localparam logic [1:0] KIND_DEC_FRAC = 2'd1;
  localparam logic [1:0] KIND_HEX      = 2'd2;
  localparam logic [1:0] KIND_BIN      = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } nlr_item_t;

  // is_number in bit 0, kind above it
  typedef struct packed {
    logic [1:0] kind;
    logic       is_number;
  } nlr_result_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return (c == CH_LO_E) || (c == CH_UP_E);
  endfunction

  function automatic scan_state_t next_state(input scan_state_t s, input logic [7:0] c);
    scan_state_t n;
    n = ST_DEAD;
    unique case (s)
      ST_START: begin
        if (is_sign(c))      n = ST_SIGNED;
        else if (c == CH_ZERO) n = ST_ZERO;
        else if (is_dec(c))  n = ST_DEC_INT;
      end
      ST_SIGNED: begin
        if (c == CH_ZERO)    n = ST_ZERO;
        else if (is_dec(c))  n = ST_DEC_INT;
      end
      ST_ZERO: begin
        if ((c == CH_LO_X) || (c == CH_UP_X))      n = ST_HEX_START;
        else if ((c == CH_LO_B) || (c == CH_UP_B)) n = ST_BIN_START;
        else if (is_dec(c))                        n = ST_DEC_INT;
        else if (c == CH_DOT)                      n = ST_DEC_DOT;
        else if (is_exp(c))                        n = ST_EXP_START;
      end
      ST_DEC_INT: begin
        if (is_dec(c))        n = ST_DEC_INT;
        else if (c == CH_DOT) n = ST_DEC_DOT;
        else if (is_exp(c))   n = ST_EXP_START;
      end
      ST_DEC_DOT: begin
        if (is_dec(c))      n = ST_DEC_DOT;
        else if (is_exp(c)) n = ST_EXP_START;
      end
      ST_EXP_START: begin
        if (is_sign(c))     n = ST_EXP_SIGN;
        else if (is_dec(c)) n = ST_EXP_DIG;
      end
      ST_EXP_SIGN, ST_EXP_DIG: begin
        if (is_dec(c)) n = ST_EXP_DIG;
      end
      ST_HEX_START, ST_HEX_DIG: begin
        if (is_hex(c)) n = ST_HEX_DIG;
      end
      ST_BIN_START, ST_BIN_DIG: begin
        if ((c == CH_ZERO) || (c == CH_ONE)) n = ST_BIN_DIG;
      end
      default: n = ST_DEAD;   // dead state and unused codes
    endcase
    return n;
  endfunction

  // Verdict for the state reached on the final character.
  function automatic nlr_result_t classify(input scan_state_t s);
    nlr_result_t r;
    r = '0;
    unique case (s)
      ST_ZERO, ST_DEC_INT: begin
        r.is_number = 1'b1;
        r.kind      = KIND_DEC_INT;
      end
      ST_DEC_DOT, ST_EXP_DIG: begin
        r.is_number = 1'b1;
        r.kind      = KIND_DEC_FRAC;
      end
      ST_HEX_DIG: begin
        r.is_number = 1'b1;
        r.kind      = KIND_HEX;
      end
      ST_BIN_DIG: begin
        r.is_number = 1'b1;
        r.kind      = KIND_BIN;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/nlr_in_reg.sv */
// Input register: captures one character beat per cycle, except while a held final beat waits for the result register.
`timescale 1ns / 1ps
module nlr_in_reg
  import nlr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  nlr_item_t in_item,
  input  logic      advance,     // held beat consumed by the scanner
  output logic      hold_valid,
  output nlr_item_t hold_item
);

  logic      valid_r, valid_nxt;
  nlr_item_t item_r;

  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) valid_nxt = in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) item_r <= in_item;
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

/* rtl/nlr_scan.sv */
// Scanner: token automaton state and the per-character transition.
`timescale 1ns / 1ps
module nlr_scan
  import nlr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        hold_valid,
  input  nlr_item_t   hold_item,
  input  logic        out_free,    // result register can take a result
  output logic        advance,
  output logic        res_load,
  output nlr_result_t res
);

  scan_state_t state_r, state_nxt;
  scan_state_t step;

  assign step    = next_state(state_r, hold_item.ch);
  // mid-token characters never wait on the output side
  assign advance = hold_valid && (!hold_item.last || out_free);
  assign res_load = advance && hold_item.last;
  assign res      = classify(step);

  always_comb begin
    state_nxt = state_r;
    if (advance) state_nxt = hold_item.last ? ST_START : step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/nlr_out_reg.sv */
// Result register toward the output channel.
`timescale 1ns / 1ps
module nlr_out_reg
  import nlr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_load,
  input  nlr_result_t res,
  output logic        out_free,
  output logic        out_tvalid,
  input  logic        out_tready,
  output nlr_result_t out_res
);

  logic        valid_r, valid_nxt;
  nlr_result_t res_r;

  assign out_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_free) valid_nxt = res_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res_r <= res;
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule

/* rtl/numeric_literal_recognizer.sv */
// A final character's verdict passes through the input register and the result register before it shows on out_tvalid.
// Throughput: one character beat per cycle, except while a final character waits for the result register to free up.
// Mid-token characters yield no output beat; only the final character does.
// Reset (rst_n low, synchronous) empties both registers and returns the
// scanner to the start-of-token state.
`timescale 1ns / 1ps
module numeric_literal_recognizer
  import nlr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tlast,   // final character of the token
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] is_number, [2:1] kind, [7:3] zero
);

  nlr_item_t   in_item;
  nlr_item_t   hold_item;
  logic        hold_valid;
  logic        advance;
  logic        res_load;
  logic        out_free;
  nlr_result_t res;
  nlr_result_t out_res;

  assign in_item.ch   = in_tdata;
  assign in_item.last = in_tlast;

  // Stage 1: character beat held for the scanner.
  nlr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // Stage 2: one automaton step per beat; verdict on the final character.
  nlr_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .out_free   (out_free),
    .advance    (advance),
    .res_load   (res_load),
    .res        (res)
  );

  // Result register: keeps mid-token input moving while a verdict waits downstream.
  nlr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_load   (res_load),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {5'b0, out_res};

endmodule

/* rtl/nlr_checker.sv */
// Port-level checker for the numeric literal recognizer, with its bind.
`timescale 1ns / 1ps
`include "numeric_literal_recognizer_defines.svh"
module nlr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  `NLR_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid, "output valid after reset")
  `NLR_ASSERT(a_stall_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled beat changed")
  `NLR_ASSERT(a_kind_zero, out_tvalid && !out_tdata[0] |-> out_tdata[2:1] == 2'd0, "kind set on rejected token")
  `NLR_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[7:3] == 5'd0, "padding bits not zero")

endmodule

bind numeric_literal_recognizer nlr_checker u_nlr_checker (.*);

/* bench/numeric_literal_recognizer_tb.sv */
// Testbench for numeric_literal_recognizer: literal scoreboard, stream drivers and checks.
`timescale 1ns / 1ps
module numeric_literal_recognizer_tb;
  import nlr_pkg::*;

  // Tracks the scan of the current token and queues one verdict per final character.
  class literal_scoreboard;
    scan_state_t lex_state;
    nlr_result_t verdict_q[$];
    int mismatches;
    int checked;
    int numbers;

    function new();
      lex_state  = ST_START;
      mismatches = 0;
      checked    = 0;
      numbers    = 0;
    endfunction

    function scan_state_t advance(scan_state_t s, logic [7:0] c);
      logic dig, hexd, sgn, ex, dot;
      dig  = (c >= CH_ZERO) && (c <= CH_NINE);
      hexd = dig || ((c >= CH_LO_A) && (c <= CH_LO_F)) || ((c >= CH_UP_A) && (c <= CH_UP_F));
      sgn  = (c == CH_PLUS) || (c == CH_MINUS);
      ex   = (c == CH_LO_E) || (c == CH_UP_E);
      dot  = (c == CH_DOT);
      case (s)
        ST_START, ST_SIGNED: begin
          if ((s == ST_START) && sgn) return ST_SIGNED;
          if (c == CH_ZERO) return ST_ZERO;
          if (dig) return ST_DEC_INT;
        end
        ST_ZERO, ST_DEC_INT: begin
          if ((s == ST_ZERO) && ((c == CH_LO_X) || (c == CH_UP_X))) return ST_HEX_START;
          if ((s == ST_ZERO) && ((c == CH_LO_B) || (c == CH_UP_B))) return ST_BIN_START;
          if (dig) return ST_DEC_INT;
          if (dot) return ST_DEC_DOT;
          if (ex) return ST_EXP_START;
        end
        ST_DEC_DOT: begin
          if (dig) return ST_DEC_DOT;
          if (ex) return ST_EXP_START;
        end
        ST_EXP_START: begin
          if (sgn) return ST_EXP_SIGN;
          if (dig) return ST_EXP_DIG;
        end
        ST_EXP_SIGN, ST_EXP_DIG: begin
          if (dig) return ST_EXP_DIG;
        end
        ST_HEX_START, ST_HEX_DIG: begin
          if (hexd) return ST_HEX_DIG;
        end
        ST_BIN_START, ST_BIN_DIG: begin
          if ((c == CH_ZERO) || (c == CH_ONE)) return ST_BIN_DIG;
        end
        default: ;
      endcase
      return ST_DEAD;
    endfunction

    // Called for every accepted character beat.
    function void note_char(logic [7:0] c, logic fin);
      scan_state_t nxt;
      nlr_result_t v;
      nxt = advance(lex_state, c);
      if (!fin) begin
        lex_state = nxt;
      end else begin
        v = '0;
        v.is_number = 1'b1;
        case (nxt)
          ST_ZERO, ST_DEC_INT:    v.kind = KIND_DEC_INT;
          ST_DEC_DOT, ST_EXP_DIG: v.kind = KIND_DEC_FRAC;
          ST_HEX_DIG:             v.kind = KIND_HEX;
          ST_BIN_DIG:             v.kind = KIND_BIN;
          default:                v = '0;
        endcase
        verdict_q.push_back(v);
        lex_state = ST_START;
      end
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $realtime, what);
    endfunction

    // Called for every accepted result beat.
    function void check_verdict(logic [7:0] data);
      nlr_result_t want;
      if (verdict_q.size() == 0) begin
        flag($sformatf("unexpected result beat, tdata=%h", data));
        return;
      end
      want = verdict_q.pop_front();
      checked++;
      if (want.is_number) numbers++;
      if (data[0] !== want.is_number)
        flag($sformatf("is_number exp %0b got %0b (tdata=%h)", want.is_number, data[0], data));
      if (data[2:1] !== want.kind)
        flag($sformatf("kind exp %0d got %0d (tdata=%h)", want.kind, data[2:1], data));
      if (data[7:3] !== 5'd0)
        flag($sformatf("pad bits exp 0 got %b (tdata=%h)", data[7:3], data));
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  literal_scoreboard sb = new();

  logic [7:0] tok_q[$];        // token under construction
  int         burst_left  = 0;
  int         chars_sent  = 0;
  int         tokens_sent = 0;

  // receiver stall pattern
  int         rx_mode   = 0;
  int         rx_cycles = 0;
  logic [2:0] rx_phase  = 3'd0;

  string hex_digits = "0123456789abcdefABCDEF";
  string soup       = "+-.0123456789abcdefxXbBeE";

  numeric_literal_recognizer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: switches among always-ready, coin-flip, sparse and periodic stalls.
  always @(posedge clk) begin
    if (rx_cycles == 0) begin
      rx_mode   <= $urandom_range(0, 3);
      rx_cycles <= $urandom_range(16, 80);
    end else begin
      rx_cycles <= rx_cycles - 1;
    end
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (rx_phase < 3'd3);
    endcase
    rx_phase <= rx_phase + 3'd1;
  end

  // Result monitor; values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_verdict(out_tdata);
  end

  // One character beat; a burst ends with a random gap with tvalid low.
  task automatic push_char(input logic [7:0] c, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    sb.note_char(c, fin);
    chars_sent++;
    if (fin) tokens_sent++;
  endtask

  task automatic send_tok_q();
    for (int i = 0; i < tok_q.size(); i++) push_char(tok_q[i], i == tok_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    tok_q.delete();
    for (int i = 0; i < s.len(); i++) tok_q.push_back(s[i]);
    send_tok_q();
  endtask

  function automatic logic [7:0] rand_dec();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic void add_digits(int n);
    for (int i = 0; i < n; i++) tok_q.push_back(rand_dec());
  endfunction

  // Zero digits now and then, to leave prefixes and exponents incomplete.
  function automatic int digit_count();
    return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
  endfunction

  // Mostly well-formed literals with random content, plus soup, noise and damage.
  function automatic void make_token();
    int shape;
    int n;
    tok_q.delete();
    shape = $urandom_range(0, 9);
    if (shape <= 6) begin
      case ($urandom_range(0, 2))
        0: tok_q.push_back(CH_PLUS);
        1: tok_q.push_back(CH_MINUS);
        default: ;
      endcase
    end
    case (shape)
      0, 1: add_digits($urandom_range(1, 6));
      2: begin
        add_digits($urandom_range(1, 4));
        tok_q.push_back(CH_DOT);
        add_digits($urandom_range(0, 4));
      end
      3: begin
        add_digits($urandom_range(1, 3));
        if ($urandom_range(0, 1)) begin
          tok_q.push_back(CH_DOT);
          add_digits($urandom_range(0, 3));
        end
        tok_q.push_back($urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
        case ($urandom_range(0, 2))
          0: tok_q.push_back(CH_PLUS);
          1: tok_q.push_back(CH_MINUS);
          default: ;
        endcase
        add_digits(digit_count());
      end
      4: begin
        tok_q.push_back(CH_ZERO);
        tok_q.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
        n = digit_count();
        for (int i = 0; i < n; i++)
          tok_q.push_back(hex_digits[$urandom_range(0, hex_digits.len() - 1)]);
      end
      5: begin
        tok_q.push_back(CH_ZERO);
        tok_q.push_back($urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
        n = digit_count();
        for (int i = 0; i < n; i++) tok_q.push_back(8'(CH_ZERO + $urandom_range(0, 1)));
      end
      6: begin
        // leading zero followed by something decimal-ish
        tok_q.push_back(CH_ZERO);
        case ($urandom_range(0, 3))
          0: ;
          1: add_digits($urandom_range(1, 3));
          2: begin
            tok_q.push_back(CH_DOT);
            add_digits($urandom_range(0, 3));
          end
          default: begin
            tok_q.push_back($urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
            add_digits($urandom_range(0, 3));
          end
        endcase
      end
      7, 8: begin
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++) tok_q.push_back(soup[$urandom_range(0, soup.len() - 1)]);
      end
      default: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) tok_q.push_back(8'($urandom_range(1, 255)));
      end
    endcase
    // damage a share of the well-formed ones
    if (shape <= 6) begin
      n = $urandom_range(0, 9);
      if (n == 0)
        tok_q[$urandom_range(0, tok_q.size() - 1)] = 8'($urandom_range(1, 255));
      else if (n == 1)
        tok_q[$urandom_range(0, tok_q.size() - 1)] = soup[$urandom_range(0, soup.len() - 1)];
      else if ((n == 2) && (tok_q.size() > 1))
        void'(tok_q.pop_back());
    end
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each literal kind, sign alone, bare prefix, dangling exponent,
    // and a high byte that kills the scan.
    send_text("0");
    send_text("+0xF");
    send_text("-0B1");
    send_text("9.5");
    send_text("1E+7");
    send_text("0x");
    send_text("+");
    send_text("1e");
    push_char(8'hFF, 1'b1);

    while (chars_sent < 620) begin
      make_token();
      send_tok_q();
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d tokens in %0d character beats; %0d verdicts checked, %0d numbers.",
             tokens_sent, chars_sent, sb.checked, sb.numbers);
    $display("Mismatches: %0d", sb.mismatches);
    if ((sb.mismatches == 0) && (sb.pending() == 0)) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timeout with %0d verdicts outstanding", sb.pending());
    $display("Verification failed");
    $finish;
  end

endmodule
